/* sv/mtpr_pkg.sv */
// Shared types and constants of the modified tanh profile block.
// Used by the front, queue, back and top level; depends on nothing.
`default_nettype none

package mtpr_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int EXP_TERMS      = 12;
    localparam int K_BITS         = 5;

    localparam logic [34:0] LN2_Q30      = 35'd744261118;
    localparam logic [45:0] EXP_BIG_T30  = 46'd23072094658;   // 31 * ln2 in Q30
    localparam logic [31:0] ZERO_Z_LIMIT = 32'd32768000;      // 500.0 in Q16.16

    localparam logic [31:0] AMPLITUDE_RST = 32'd65536;
    localparam logic [31:0] OFFSET_RST    = 32'd196608;
    localparam logic [31:0] SLOPE_RST     = 32'd655;
    localparam logic [31:0] SYMMETRY_RST  = 32'd65536;
    localparam logic [30:0] HALF_WIDTH_RST = 31'd655;

    typedef enum logic [2:0] {
        REG_AMPLITUDE  = 3'd0,
        REG_OFFSET     = 3'd1,
        REG_CORE_SLOPE = 3'd2,
        REG_SYMMETRY   = 3'd3,
        REG_HALF_WIDTH = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] amp;
        logic signed [31:0] off;
        logic signed [31:0] alpha;
        logic signed [31:0] xsym;
        logic        [30:0] hwid;
    } t_cfg;

    typedef struct packed {
        logic               req;
        logic               last;
        logic               zrule;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] ey;
    } t_item;

endpackage

`default_nettype wire

/* sv/mtpr_front.sv */
// Front end: accepts items from the input channel and classifies them.
// Depends on mtpr_pkg; feeds mtpr_queue.
`default_nettype none

module mtpr_front import mtpr_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_req_type,
    input  wire logic signed [31:0] i_x_pos,
    input  wire logic signed [31:0] i_y_meas,
    input  wire logic signed [31:0] i_y_err,
    input  wire logic               i_last_point,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output t_item                   o_item
);

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign o_in_stall = r_valid & i_q_full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_push     = r_valid & ~i_q_full;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_item.req   <= i_req_type;
            r_item.last  <= i_last_point;
            // Residual points with no measurement or no error bar are marked for a forced-zero result.
            r_item.zrule <= i_req_type & ((i_y_meas == 32'sd0) | (i_y_err == 32'sd0));
            r_item.x     <= i_x_pos;
            r_item.y     <= i_y_meas;
            r_item.ey    <= i_y_err;
        end
    end

endmodule

`default_nettype wire

/* sv/mtpr_queue.sv */
// Short item queue between the front end and the arithmetic back end.
// Depends on mtpr_pkg for the item type.
`default_nettype none

module mtpr_queue import mtpr_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_item     i_item,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_item     o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push & ~do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop & ~do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* sv/mtpr_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Needs i_num < i_den * 2^QW. Stand-alone; used by mtpr_back.
`default_nettype none

module mtpr_div #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int QW = 32,
    parameter int SW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_vld,
    output logic [QW-1:0]      o_quo,
    output logic [SW-1:0]      o_side
);

    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_nlo  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];
    logic [QW-1:0] r_vld;

    logic [DW-1:0] w_rem  [QW];
    logic [QW-1:0] w_nlo  [QW];
    logic [QW-1:0] w_quo  [QW];
    logic [DW-1:0] w_den  [QW];
    logic [SW-1:0] w_side [QW];
    logic [QW-1:0] w_vld;

    logic [NW+DW-1:0] num_ext;
    assign num_ext = (NW + DW)'(i_num) >> QW;

    genvar gi;
    generate
        for (gi = 0; gi < QW; gi++) begin : g_stage
            logic [DW:0]   trial;
            logic          ge;
            if (gi == 0) begin : g_head
                assign w_rem[gi]  = num_ext[DW-1:0];
                assign w_nlo[gi]  = i_num[QW-1:0];
                assign w_quo[gi]  = '0;
                assign w_den[gi]  = i_den;
                assign w_side[gi] = i_side;
                assign w_vld[gi]  = i_vld;
            end else begin : g_body
                assign w_rem[gi]  = r_rem[gi-1];
                assign w_nlo[gi]  = r_nlo[gi-1];
                assign w_quo[gi]  = r_quo[gi-1];
                assign w_den[gi]  = r_den[gi-1];
                assign w_side[gi] = r_side[gi-1];
                assign w_vld[gi]  = r_vld[gi-1];
            end
            assign trial = {w_rem[gi], w_nlo[gi][QW-1-gi]};
            assign ge    = (trial >= {1'b0, w_den[gi]});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[gi] <= 1'b0;
                end else if (i_en) begin
                    r_vld[gi] <= w_vld[gi];
                end
                if (i_en) begin
                    r_rem[gi]  <= ge ? DW'(trial - {1'b0, w_den[gi]}) : trial[DW-1:0];
                    r_nlo[gi]  <= w_nlo[gi];
                    r_quo[gi]  <= w_quo[gi] | (QW'(ge) << (QW - 1 - gi));
                    r_den[gi]  <= w_den[gi];
                    r_side[gi] <= w_side[gi];
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[QW-1];
    assign o_quo  = r_quo[QW-1];
    assign o_side = r_side[QW-1];

endmodule

`default_nettype wire

/* sv/mtpr_back.sv */
// Arithmetic back end: z division, exponential series, model value and
// weighted residual, as one stalling pipeline. Depends on mtpr_pkg, mtpr_div.
`default_nettype none

module mtpr_back import mtpr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  t_cfg        i_cfg,
    input  wire logic   i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    input  wire logic   i_out_stall,
    output logic        o_out_valid,
    output logic [31:0] o_result_value,
    output logic        o_zeroed,
    output logic        o_saturated,
    output logic        o_last_out
);

    typedef struct packed {
        logic               vld;
        logic               req;
        logic               last;
        logic               zrule;
        logic signed [31:0] y;
        logic signed [31:0] ey;
        logic signed [31:0] zc;
        logic               ebig;
        logic [K_BITS-1:0]  k;
        logic [34:0]        rem35;
        logic [30:0]        term;
        logic [30:0]        tv;
        logic signed [32:0] acc;
        logic [16:0]        e;
        logic signed [31:0] p;
        logic signed [63:0] prod;
        logic signed [47:0] f;
        logic               dneg;
        logic               dover;
        logic [65:0]        dnum;
        logic [31:0]        dden;
    } t_ctx;

    localparam int CW = $bits(t_ctx);

    logic en;
    logic r_out_vld;
    logic [31:0] r_out_val;
    logic r_out_zero, r_out_sat, r_out_last;

    // The whole pipeline moves together unless a finished result is held.
    assign en          = ~(r_out_vld & i_out_stall);
    assign o_q_pop     = en & i_q_valid;
    assign o_out_valid = r_out_vld;
    assign o_result_value = r_out_val;
    assign o_zeroed    = r_out_zero;
    assign o_saturated = r_out_sat;
    assign o_last_out  = r_out_last;

    // ---------------- z = (xsym - x) / hwid set-up ----------------
    t_ctx n_s1, r_s1;
    always_comb begin
        logic signed [32:0] d;
        logic [32:0]        dmag;
        logic [30:0]        den;
        logic [48:0]        numz;
        logic               over;
        d    = {i_cfg.xsym[31], i_cfg.xsym} - {i_q_item.x[31], i_q_item.x};
        dmag = d[32] ? $unsigned(-d) : $unsigned(d);
        den  = (i_cfg.hwid == '0) ? 31'd1 : i_cfg.hwid;
        numz = {dmag, 16'd0};
        over = ({14'd0, numz} >= {den, 32'd0});
        n_s1       = '0;
        n_s1.vld   = i_q_valid;
        n_s1.req   = i_q_item.req;
        n_s1.last  = i_q_item.last;
        n_s1.zrule = i_q_item.zrule;
        n_s1.y     = i_q_item.y;
        n_s1.ey    = i_q_item.ey;
        n_s1.dneg  = d[32];
        n_s1.dover = over;
        n_s1.dnum  = over ? '0 : 66'(numz);
        n_s1.dden  = 32'(den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else if (en) begin
            r_s1 <= n_s1;
        end
    end

    logic          zd_vld;
    logic [31:0]   zd_quo;
    logic [CW-1:0] zd_side;

    mtpr_div #(.NW(49), .DW(31), .QW(32), .SW(CW)) u_zdiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_s1.vld),
        .i_num  (r_s1.dnum[48:0]),
        .i_den  (r_s1.dden[30:0]),
        .i_side (r_s1),
        .o_vld  (zd_vld),
        .o_quo  (zd_quo),
        .o_side (zd_side)
    );

    // ---------------- clamp z, huge-z rule, exponent argument ----------------
    t_ctx n_s2, r_s2;
    always_comb begin
        logic [30:0] zmag;
        logic        zbig;
        logic [45:0] t30;
        n_s2     = t_ctx'(zd_side);
        n_s2.vld = zd_vld;
        zmag = (n_s2.dover | zd_quo[31]) ? 31'h7FFF_FFFF : zd_quo[30:0];
        zbig = ~n_s2.dneg & (n_s2.dover | (zd_quo >= ZERO_Z_LIMIT));
        n_s2.zrule = n_s2.zrule | (n_s2.req & zbig);
        n_s2.zc    = n_s2.dneg ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
        t30        = {zmag, 15'd0};
        n_s2.ebig  = (t30 >= EXP_BIG_T30);
        n_s2.rem35 = t30[34:0];
        n_s2.k     = '0;
        n_s2.term  = 31'h4000_0000;
        n_s2.acc   = 33'sh0_4000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.vld <= 1'b0;
        end else if (en) begin
            r_s2 <= n_s2;
        end
    end

    // ---------------- k = floor(t / ln2), one bit per stage ----------------
    t_ctx r_k [K_BITS];
    t_ctx w_kin [K_BITS];

    genvar gj;
    generate
        for (gj = 0; gj < K_BITS; gj++) begin : g_kstep
            localparam logic [34:0] SH = LN2_Q30 << (K_BITS - 1 - gj);
            t_ctx n_k;
            if (gj == 0) begin : g_head
                assign w_kin[gj] = r_s2;
            end else begin : g_body
                assign w_kin[gj] = r_k[gj-1];
            end
            always_comb begin
                n_k = w_kin[gj];
                if (n_k.rem35 >= SH) begin
                    n_k.rem35 = n_k.rem35 - SH;
                    n_k.k[K_BITS-1-gj] = 1'b1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_k[gj].vld <= 1'b0;
                end else if (en) begin
                    r_k[gj] <= n_k;
                end
            end
        end
    endgenerate

    // ---------------- e^-r series: multiply, reciprocal, correct ----------------
    t_ctx r_ta [EXP_TERMS];
    t_ctx r_tb [EXP_TERMS];
    t_ctx r_tc [EXP_TERMS];
    t_ctx w_tin [EXP_TERMS];

    genvar gn;
    generate
        for (gn = 0; gn < EXP_TERMS; gn++) begin : g_term
            localparam int N = gn + 1;
            localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N);
            t_ctx n_a, n_b, n_c;
            if (gn == 0) begin : g_head
                assign w_tin[gn] = r_k[K_BITS-1];
            end else begin : g_body
                assign w_tin[gn] = r_tc[gn-1];
            end

            always_comb begin
                n_a      = w_tin[gn];
                n_a.prod = $signed(64'(n_a.term) * 64'(n_a.rem35[29:0]));
            end

            always_comb begin
                n_b      = r_ta[gn];
                n_b.tv   = n_b.prod[60:30];
                n_b.prod = $signed(64'(n_b.prod[60:30]) * 64'(RECIP));
            end

            // The reciprocal estimate is at most one below the true quotient.
            always_comb begin
                logic [30:0] q0;
                logic [34:0] qn;
                logic [30:0] rd;
                logic [30:0] q;
                n_c = r_tb[gn];
                q0  = n_c.prod[62:32];
                qn  = 35'(q0) * 35'(N);
                rd  = n_c.tv - qn[30:0];
                q   = (rd >= 31'(N)) ? q0 + 31'd1 : q0;
                n_c.term = q;
                if (N % 2 == 1) begin
                    n_c.acc = n_c.acc - $signed({2'b00, q});
                end else begin
                    n_c.acc = n_c.acc + $signed({2'b00, q});
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ta[gn].vld <= 1'b0;
                    r_tb[gn].vld <= 1'b0;
                    r_tc[gn].vld <= 1'b0;
                end else if (en) begin
                    r_ta[gn] <= n_a;
                    r_tb[gn] <= n_b;
                    r_tc[gn] <= n_c;
                end
            end
        end
    endgenerate

    // ---------------- E rounding, alpha * z ----------------
    t_ctx n_se, r_se;
    always_comb begin
        logic signed [32:0] e30;
        logic [32:0]        er;
        n_se = r_tc[EXP_TERMS-1];
        e30  = n_se.acc >>> n_se.k;
        er   = $unsigned(e30) + 33'd8192;
        n_se.e    = n_se.ebig ? 17'd0 : er[30:14];
        n_se.prod = 64'(i_cfg.alpha) * 64'(n_se.zc);
    end

    // ---------------- p = 1 + alpha*z, clamped ----------------
    t_ctx n_sp, r_sp;
    always_comb begin
        logic signed [48:0] ps;
        n_sp = r_se;
        ps   = 49'sd65536 + 49'(n_sp.prod >>> FRAC_BITS);
        if (ps > 49'sd1073741823) begin
            n_sp.p = 32'sd1073741823;
        end else if (ps < -49'sd1073741823) begin
            n_sp.p = -32'sd1073741823;
        end else begin
            n_sp.p = ps[31:0];
        end
    end

    t_ctx n_sn1, r_sn1;
    always_comb begin
        n_sn1      = r_sp;
        n_sn1.prod = 64'(n_sn1.p) * 64'($signed({1'b0, n_sn1.e}));
    end

    // ---------------- numerator of mt, divider set-up ----------------
    t_ctx n_sn2, r_sn2;
    always_comb begin
        logic signed [31:0] nv;
        logic [31:0]        nmag;
        n_sn2 = r_sn1;
        if (!n_sn2.zc[31]) begin
            nv = n_sn2.p - $signed({15'd0, n_sn2.e});
        end else begin
            nv = 32'(n_sn2.prod >>> FRAC_BITS) - 32'sd65536;
        end
        nmag        = nv[31] ? $unsigned(-nv) : $unsigned(nv);
        n_sn2.dneg  = nv[31];
        n_sn2.dover = 1'b0;
        n_sn2.dnum  = 66'({nmag, 16'd0});
        n_sn2.dden  = 32'd65536 + 32'(n_sn2.e);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_se.vld  <= 1'b0;
            r_sp.vld  <= 1'b0;
            r_sn1.vld <= 1'b0;
            r_sn2.vld <= 1'b0;
        end else if (en) begin
            r_se  <= n_se;
            r_sp  <= n_sp;
            r_sn1 <= n_sn1;
            r_sn2 <= n_sn2;
        end
    end

    logic          md_vld;
    logic [30:0]   md_quo;
    logic [CW-1:0] md_side;

    mtpr_div #(.NW(48), .DW(18), .QW(31), .SW(CW)) u_mdiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_sn2.vld),
        .i_num  (r_sn2.dnum[47:0]),
        .i_den  (r_sn2.dden[17:0]),
        .i_side (r_sn2),
        .o_vld  (md_vld),
        .o_quo  (md_quo),
        .o_side (md_side)
    );

    // ---------------- a * mt, then f and residual set-up ----------------
    t_ctx n_sm, r_sm;
    always_comb begin
        logic signed [31:0] mt;
        n_sm     = t_ctx'(md_side);
        n_sm.vld = md_vld;
        mt       = n_sm.dneg ? -$signed({1'b0, md_quo}) : $signed({1'b0, md_quo});
        n_sm.prod = 64'(i_cfg.amp) * 64'(mt);
    end

    t_ctx n_sf, r_sf;
    always_comb begin
        logic signed [49:0] d;
        logic [49:0]        dmag;
        logic [31:0]        den;
        logic [65:0]        num;
        logic               over;
        n_sf   = r_sm;
        n_sf.f = 48'(n_sf.prod >>> FRAC_BITS) + 48'(i_cfg.off);
        d      = 50'(n_sf.y) - 50'(n_sf.f);
        dmag   = d[49] ? $unsigned(-d) : $unsigned(d);
        den    = n_sf.ey[31] ? $unsigned(-n_sf.ey) : $unsigned(n_sf.ey);
        num    = {dmag, 16'd0};
        over   = (num >= {2'b00, den, 32'd0});
        n_sf.dneg  = d[49] ^ n_sf.ey[31];
        n_sf.dover = over;
        n_sf.dnum  = over ? '0 : num;
        n_sf.dden  = den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm.vld <= 1'b0;
            r_sf.vld <= 1'b0;
        end else if (en) begin
            r_sm <= n_sm;
            r_sf <= n_sf;
        end
    end

    logic          rd_vld;
    logic [31:0]   rd_quo;
    logic [CW-1:0] rd_side;

    mtpr_div #(.NW(66), .DW(32), .QW(32), .SW(CW)) u_rdiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_sf.vld),
        .i_num  (r_sf.dnum),
        .i_den  (r_sf.dden),
        .i_side (r_sf),
        .o_vld  (rd_vld),
        .o_quo  (rd_quo),
        .o_side (rd_side)
    );

    // ---------------- result selection and saturation ----------------
    t_ctx        c_out;
    logic [31:0] n_val;
    logic        n_zero, n_sat;
    always_comb begin
        c_out  = t_ctx'(rd_side);
        n_zero = 1'b0;
        n_sat  = 1'b0;
        n_val  = '0;
        if (!c_out.req) begin
            if (c_out.f > 48'sh0000_7FFF_FFFF) begin
                n_val = 32'h7FFF_FFFF;
                n_sat = 1'b1;
            end else if (c_out.f < -48'sh0000_8000_0000) begin
                n_val = 32'h8000_0000;
                n_sat = 1'b1;
            end else begin
                n_val = c_out.f[31:0];
            end
        end else if (c_out.zrule) begin
            n_zero = 1'b1;
        end else if (c_out.dneg) begin
            if (c_out.dover | (rd_quo > 32'h8000_0000)) begin
                n_val = 32'h8000_0000;
                n_sat = 1'b1;
            end else begin
                n_val = 32'(-rd_quo);
            end
        end else begin
            if (c_out.dover | rd_quo[31]) begin
                n_val = 32'h7FFF_FFFF;
                n_sat = 1'b1;
            end else begin
                n_val = rd_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= rd_vld;
        end
        if (en) begin
            r_out_val  <= n_val;
            r_out_zero <= n_zero;
            r_out_sat  <= n_sat;
            r_out_last <= c_out.last;
        end
    end

endmodule

`default_nettype wire

/* sv/mtanh_profile_residual.sv */
// Top level of the modified tanh profile evaluator and residual block.
// Holds the configuration registers; depends on mtpr_pkg, mtpr_front,
// mtpr_queue and mtpr_back.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    req_type x_pos y_meas y_err last_point
//   result    out        o_out_valid / i_out_stall  result_value zeroed saturated last_out
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item is accepted and one result delivered every cycle when neither side stalls.
// The pipeline length is dominated by the three bit-per-stage dividers and
// the twelve three-stage terms of the exponential series.
// Reset is synchronous and restores the register defaults; no clearing pass.
// An output stall freezes the back pipeline; the queue absorbs up to QUEUE_DEPTH items.
`default_nettype none

module mtanh_profile_residual import mtpr_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_req_type,
    input  wire logic signed [31:0] i_x_pos,
    input  wire logic signed [31:0] i_y_meas,
    input  wire logic signed [31:0] i_y_err,
    input  wire logic               i_last_point,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_result_value,
    output logic                    o_zeroed,
    output logic                    o_saturated,
    output logic                    o_last_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    t_cfg  r_cfg;
    t_item f_item, q_item;
    logic  f_push, q_full, q_valid, q_pop;
    logic [31:0] res_val;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.amp   <= AMPLITUDE_RST;
            r_cfg.off   <= OFFSET_RST;
            r_cfg.alpha <= SLOPE_RST;
            r_cfg.xsym  <= SYMMETRY_RST;
            r_cfg.hwid  <= HALF_WIDTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_AMPLITUDE:  r_cfg.amp   <= i_cfg_data;
                REG_OFFSET:     r_cfg.off   <= i_cfg_data;
                REG_CORE_SLOPE: r_cfg.alpha <= i_cfg_data;
                REG_SYMMETRY:   r_cfg.xsym  <= i_cfg_data;
                REG_HALF_WIDTH: r_cfg.hwid  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    mtpr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_x_pos     (i_x_pos),
        .i_y_meas    (i_y_meas),
        .i_y_err     (i_y_err),
        .i_last_point(i_last_point),
        .i_q_full    (q_full),
        .o_push      (f_push),
        .o_item      (f_item)
    );

    mtpr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (f_push),
        .i_item (f_item),
        .o_full (q_full),
        .o_valid(q_valid),
        .i_pop  (q_pop),
        .o_item (q_item)
    );

    mtpr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_result_value(res_val),
        .o_zeroed      (o_zeroed),
        .o_saturated   (o_saturated),
        .o_last_out    (o_last_out)
    );

    assign o_result_value = $signed(res_val);

endmodule

`default_nettype wire

/* sv/mtpr_checker.sv */
// Port-level checks for mtanh_profile_residual, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module mtpr_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic signed [31:0] o_result_value,
    input wire logic               o_zeroed,
    input wire logic               o_saturated,
    input wire logic               o_last_out
);

    // A held result keeps its value and flags.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_value)
            && $stable(o_zeroed) && $stable(o_saturated) && $stable(o_last_out))
        else $error("held result changed");

    // A forced-zero residual is exactly zero and never flagged as clipped.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zeroed |-> (o_result_value == 32'sd0) && !o_saturated)
        else $error("zeroed result not clean");

    // A clipped result sits on one of the two range limits.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> (o_result_value == 32'sh7FFF_FFFF)
            || (o_result_value == -32'sh8000_0000))
        else $error("saturated result off the limits");

    // Nothing is delivered straight after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind mtanh_profile_residual mtpr_checker u_mtpr_checker (.*);

`default_nettype wire
